// ----- rtl/dma_descriptor_list_builder_assert.svh -----
// Assertion macros for the checker of the descriptor list builder.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef DMA_DESCRIPTOR_LIST_BUILDER_ASSERT_SVH
`define DMA_DESCRIPTOR_LIST_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define DLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dlb_pkg.sv -----
package dlb_pkg;

    localparam int ADDR_W    = 64;
    localparam int CNT_W     = 32;
    localparam int CTL_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Control word bits
    localparam logic [CTL_W-1:0] CTL_CB  = 5'b00001;
    localparam logic [CTL_W-1:0] CTL_TCB = 5'b00010;
    localparam logic [CTL_W-1:0] CTL_LLP = 5'b00100;
    localparam logic [CTL_W-1:0] CTL_LIE = 5'b01000;
    localparam logic [CTL_W-1:0] CTL_RIE = 5'b10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_DIRECTION = 2'd0,
        CFG_CYCLE_BIT      = 2'd1,
        CFG_LIST_BASE      = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_LINK = 1'b1
    } elem_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [CNT_W-1:0]  byte_count;
        logic              last_burst;
    } burst_t;

    typedef struct packed {
        elem_kind_t        elem_kind;
        logic [CTL_W-1:0]  ctl_word;
        logic [CNT_W-1:0]  out_count;
        logic [ADDR_W-1:0] out_src;
        logic [ADDR_W-1:0] out_dst;
        logic              run_end;
    } desc_t;

endpackage

// ----- rtl/dlb_burst_if.sv -----
interface dlb_burst_if;
    logic                      valid;
    logic                      ready;
    logic [dlb_pkg::ADDR_W-1:0] src_addr;
    logic [dlb_pkg::ADDR_W-1:0] dst_addr;
    logic [dlb_pkg::CNT_W-1:0]  byte_count;
    logic                      last_burst;

    modport source (output valid, output src_addr, output dst_addr,
                     output byte_count, output last_burst, input ready);
    modport sink   (input valid, input src_addr, input dst_addr,
                     input byte_count, input last_burst, output ready);
endinterface

// ----- rtl/dlb_desc_if.sv -----
interface dlb_desc_if;
    logic                      valid;
    logic                      ready;
    logic                      elem_kind;
    logic [dlb_pkg::CTL_W-1:0]  ctl_word;
    logic [dlb_pkg::CNT_W-1:0]  out_count;
    logic [dlb_pkg::ADDR_W-1:0] out_src;
    logic [dlb_pkg::ADDR_W-1:0] out_dst;
    logic                      run_end;

    modport source (output valid, output elem_kind, output ctl_word, output out_count,
                     output out_src, output out_dst, output run_end, input ready);
    modport sink   (input valid, input elem_kind, input ctl_word, input out_count,
                     input out_src, input out_dst, input run_end, output ready);
endinterface

// ----- rtl/dlb_cfg_if.sv -----
interface dlb_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dlb_pkg::CFG_IDX_W-1:0] index;
    logic [dlb_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dma_descriptor_list_builder.sv -----
// The first descriptor word of a burst passes through the input register, then the descriptor
// register, before it is presented; a full descriptor register holds the burst back.
// One burst per cycle is taken while the descriptor register is free; a burst emits 0 to 3
// words, and the output port, one word per cycle while desc.ready is high, sets the rate.
// Reset (rst_n, asynchronous, active low): no element pending, no word held, all
// configuration registers zero.
module dma_descriptor_list_builder (
    input  logic        clk,
    input  logic        rst_n,
    dlb_burst_if.sink   burst,
    dlb_desc_if.source  desc,
    dlb_cfg_if.sink     cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle;
    // the block itself does not enforce this. The port is always ready.
    // ------------------------------------------------------------------
    logic                      dir_reg, dir_next;
    logic                      cb_reg, cb_next;
    logic [dlb_pkg::ADDR_W-1:0] base_reg, base_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        dir_next  = dir_reg;
        cb_next   = cb_reg;
        base_next = base_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dlb_pkg::CFG_READ_DIRECTION: dir_next  = cfg.data[0];
                dlb_pkg::CFG_CYCLE_BIT:      cb_next   = cfg.data[0];
                dlb_pkg::CFG_LIST_BASE:      base_next = cfg.data;
                default:                     ; // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one burst while the descriptor register drains.
    // ------------------------------------------------------------------
    logic            in_vld_reg, in_vld_next;
    dlb_pkg::burst_t in_reg, in_next;
    logic            move;      // burst in the input register is processed now

    assign burst.ready = !in_vld_reg || move;

    always_comb
    begin
        in_next     = in_reg;
        in_vld_next = in_vld_reg && !move;
        if (burst.valid && burst.ready)
        begin
            in_next.src_addr   = burst.src_addr;
            in_next.dst_addr   = burst.dst_addr;
            in_next.byte_count = burst.byte_count;
            in_next.last_burst = burst.last_burst;
            in_vld_next        = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Pending element and the merge decision.
    // ------------------------------------------------------------------
    logic                      pend_vld_reg, pend_vld_next;
    logic [dlb_pkg::ADDR_W-1:0] pend_src_reg, pend_src_next;
    logic [dlb_pkg::ADDR_W-1:0] pend_dst_reg, pend_dst_next;
    logic [dlb_pkg::CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [dlb_pkg::ADDR_W-1:0] have_addr;
    logic [dlb_pkg::ADDR_W-1:0] cont_addr;
    logic [dlb_pkg::CNT_W:0]    cnt_sum;
    logic                      merge;
    logic                      emit_old;

    // Element after this burst, before the last-burst flush
    logic [dlb_pkg::ADDR_W-1:0] new_src;
    logic [dlb_pkg::ADDR_W-1:0] new_dst;
    logic [dlb_pkg::CNT_W-1:0]  new_cnt;

    always_comb
    begin
        have_addr = dir_reg ? in_reg.src_addr : in_reg.dst_addr;
        // Continuation address wraps modulo 2^64
        cont_addr = (dir_reg ? pend_src_reg : pend_dst_reg)
                  + {{(dlb_pkg::ADDR_W - dlb_pkg::CNT_W){1'b0}}, pend_cnt_reg};
        cnt_sum   = {1'b0, pend_cnt_reg} + {1'b0, in_reg.byte_count};
        // A size sum that leaves 32 bits starts a new element instead
        merge     = pend_vld_reg && (have_addr == cont_addr) && !cnt_sum[dlb_pkg::CNT_W];
        emit_old  = pend_vld_reg && !merge;

        if (merge)
        begin
            new_src = pend_src_reg;
            new_dst = pend_dst_reg;
            new_cnt = cnt_sum[dlb_pkg::CNT_W-1:0];
        end
        else
        begin
            new_src = in_reg.src_addr;
            new_dst = in_reg.dst_addr;
            new_cnt = in_reg.byte_count;
        end
    end

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_src_next = pend_src_reg;
        pend_dst_next = pend_dst_reg;
        pend_cnt_next = pend_cnt_reg;
        if (move)
        begin
            // The last burst flushes everything: nothing stays pending
            pend_vld_next = !in_reg.last_burst;
            pend_src_next = new_src;
            pend_dst_next = new_dst;
            pend_cnt_next = new_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Descriptors caused by this burst, in output order:
    //   displaced element, final data descriptor, link descriptor.
    // ------------------------------------------------------------------
    dlb_pkg::desc_t            old_desc, fin_desc, link_desc;
    dlb_pkg::desc_t            grp_desc [3];
    logic [1:0]                grp_cnt;
    logic [dlb_pkg::CTL_W-1:0] cb_ctl;

    always_comb
    begin
        cb_ctl = cb_reg ? dlb_pkg::CTL_CB : '0;

        old_desc.elem_kind = dlb_pkg::KIND_DATA;
        old_desc.ctl_word  = cb_ctl;
        old_desc.out_count = pend_cnt_reg;
        old_desc.out_src   = pend_src_reg;
        old_desc.out_dst   = pend_dst_reg;
        old_desc.run_end   = 1'b0;

        fin_desc.elem_kind = dlb_pkg::KIND_DATA;
        fin_desc.ctl_word  = cb_ctl | dlb_pkg::CTL_LIE | dlb_pkg::CTL_RIE;
        fin_desc.out_count = new_cnt;
        fin_desc.out_src   = new_src;
        fin_desc.out_dst   = new_dst;
        fin_desc.run_end   = 1'b0;

        // Link descriptor carries the inverted cycle bit
        link_desc.elem_kind = dlb_pkg::KIND_LINK;
        link_desc.ctl_word  = dlb_pkg::CTL_LLP | dlb_pkg::CTL_TCB
                            | (cb_reg ? '0 : dlb_pkg::CTL_CB);
        link_desc.out_count = '0;
        link_desc.out_src   = base_reg;
        link_desc.out_dst   = '0;
        link_desc.run_end   = 1'b1;

        grp_desc[0] = emit_old ? old_desc : fin_desc;
        grp_desc[1] = emit_old ? fin_desc : link_desc;
        grp_desc[2] = link_desc;
        // 0, 1, 2 or 3 words: displaced element plus two for the last burst
        grp_cnt     = {in_reg.last_burst, emit_old};
    end

    // ------------------------------------------------------------------
    // Descriptor register: up to three words, slot 0 faces the port.
    // Advance by shifting down as words are taken.
    // ------------------------------------------------------------------
    dlb_pkg::desc_t slot_reg [3];
    dlb_pkg::desc_t slot_next [3];
    logic [1:0]     left_reg, left_next;
    logic           take;
    logic           grp_free;

    assign take     = desc.valid && desc.ready;
    assign grp_free = (left_reg == 2'd0) || ((left_reg == 2'd1) && take);
    assign move     = in_vld_reg && grp_free;

    always_comb
    begin
        slot_next = slot_reg;
        left_next = left_reg;
        if (move)
        begin
            slot_next = grp_desc;
            left_next = grp_cnt;
        end
        else if (take)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            left_next    = left_reg - 2'd1;
        end
    end

    assign desc.valid     = (left_reg != 2'd0);
    assign desc.elem_kind = slot_reg[0].elem_kind;
    assign desc.ctl_word  = slot_reg[0].ctl_word;
    assign desc.out_count = slot_reg[0].out_count;
    assign desc.out_src   = slot_reg[0].out_src;
    assign desc.out_dst   = slot_reg[0].out_dst;
    assign desc.run_end   = slot_reg[0].run_end;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= 1'b0;
            cb_reg       <= 1'b0;
            base_reg     <= '0;
            in_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            left_reg     <= 2'd0;
        end
        else
        begin
            dir_reg      <= dir_next;
            cb_reg       <= cb_next;
            base_reg     <= base_next;
            in_vld_reg   <= in_vld_next;
            pend_vld_reg <= pend_vld_next;
            left_reg     <= left_next;
        end
    end

    // Payload: only read while its valid flag is set
    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        pend_src_reg <= pend_src_next;
        pend_dst_reg <= pend_dst_next;
        pend_cnt_reg <= pend_cnt_next;
        slot_reg     <= slot_next;
    end

endmodule

// ----- rtl/dlb_checker.sv -----
`include "dma_descriptor_list_builder_assert.svh"

module dlb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_kind,
    input logic [dlb_pkg::CTL_W-1:0]  out_ctl,
    input logic [dlb_pkg::CNT_W-1:0]  out_count,
    input logic [dlb_pkg::ADDR_W-1:0] out_src
);

    logic in_take;
    logic out_take;
    logic out_stall;
    logic fin_take;

    assign in_take   = in_valid && in_ready;
    assign out_take  = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;
    assign fin_take  = out_take && (out_kind == dlb_pkg::KIND_DATA)
                     && ((out_ctl & dlb_pkg::CTL_LIE) != '0);

    // Hold a stalled word
    `DLB_ASSERT_NEXT(a_out_hold, out_stall,
        out_valid && $stable(out_kind) && $stable(out_ctl) && $stable(out_count)
        && $stable(out_src), "descriptor word changed while stalled")

    // A final data descriptor is always followed at once by its link descriptor
    `DLB_ASSERT_NEXT(a_link_follows, fin_take,
        out_valid && (out_kind == dlb_pkg::KIND_LINK),
        "final data descriptor not followed by link descriptor")

    // Link descriptor carries toggle and link but never irq bits
    `DLB_ASSERT_NOW(a_link_ctl, out_valid && (out_kind == dlb_pkg::KIND_LINK),
        ((out_ctl & (dlb_pkg::CTL_LLP | dlb_pkg::CTL_TCB))
            == (dlb_pkg::CTL_LLP | dlb_pkg::CTL_TCB))
        && ((out_ctl & (dlb_pkg::CTL_LIE | dlb_pkg::CTL_RIE)) == '0)
        && (out_count == '0), "malformed link descriptor")

    // A burst taken during an output stall fills the input register:
    // no further burst while the stall lasts
    `DLB_ASSERT_NOW(a_backpressure, out_stall && $past(in_take && out_stall),
        !in_ready, "burst accepted past a full input register")

endmodule

bind dma_descriptor_list_builder dlb_checker u_dlb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (burst.valid),
    .in_ready  (burst.ready),
    .out_valid (desc.valid),
    .out_ready (desc.ready),
    .out_kind  (desc.elem_kind),
    .out_ctl   (desc.ctl_word),
    .out_count (desc.out_count),
    .out_src   (desc.out_src)
);
